@@ hw/rtl/aaap_pkg.sv @@
// aaap_pkg: widths, codes, reset values and display tables for the audio
// activity auto power block. No dependencies; used by all other files.
package aaap_pkg;

  localparam int DIGIT_BITS = 4;
  localparam int DIGITS     = 6;
  localparam int WORD_BITS  = DIGIT_BITS * DIGITS;
  localparam int CNT_BITS   = $clog2(DIGITS + 2);
  localparam int LANES      = 4;

  localparam int KIND_BITS    = 2;
  localparam int THRESH_BITS  = 10;
  localparam int IDLE_BITS    = 16;
  localparam int BUTTON_BITS  = 22;
  localparam int STEP_BITS    = 16;
  localparam int SPIN_BITS    = 4;
  localparam int LEVEL_BITS   = 4;
  localparam int SEG_BITS     = 8;
  localparam int SPIN_LOW     = 5;
  localparam int SEG_DP_BIT   = 1;
  localparam int FIVE_BITS    = IDLE_BITS + 3;
  localparam int REM_BITS     = IDLE_BITS + 4;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = BUTTON_BITS;

  localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_POLL   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESH     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BTN_LIMIT  = 2'd2;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET     = 10'd80;
  localparam logic [IDLE_BITS-1:0]   IDLE_LIMIT_RESET = 16'd14648;
  localparam logic [BUTTON_BITS-1:0] BTN_LIMIT_RESET  = 22'd1757813;
  localparam logic [STEP_BITS-1:0]   STEP_RESET       = 16'd1;

  typedef struct packed {
    logic load;
    logic shift;
    logic sub;
  } lane_ctl_t;

  function automatic logic [SEG_BITS-1:0] digit_seg(input logic [LEVEL_BITS-1:0] lvl);
    logic [SEG_BITS-1:0] s;
    case (lvl)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h0C;
      4'd2:    s = 8'h79;
      4'd3:    s = 8'h3D;
      4'd4:    s = 8'h8D;
      4'd5:    s = 8'hB5;
      4'd6:    s = 8'hF5;
      4'd7:    s = 8'h1C;
      4'd8:    s = 8'hFD;
      4'd9:    s = 8'hBD;
      4'd10:   s = 8'hDD;
      4'd11:   s = 8'hE5;
      4'd12:   s = 8'hF0;
      4'd13:   s = 8'h6D;
      4'd14:   s = 8'hF1;
      4'd15:   s = 8'hD1;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_BITS-1:0] spin_seg(input logic [SPIN_BITS-1:0] idx);
    logic [SEG_BITS-1:0] s;
    case (idx)
      4'd0:    s = 8'h01;
      4'd1:    s = 8'h09;
      4'd2:    s = 8'h08;
      4'd3:    s = 8'h18;
      4'd4:    s = 8'h10;
      4'd5:    s = 8'h90;
      4'd6:    s = 8'h80;
      4'd7:    s = 8'h81;
      4'd8:    s = 8'h01;
      4'd9:    s = 8'h05;
      4'd10:   s = 8'h04;
      4'd11:   s = 8'h24;
      4'd12:   s = 8'h20;
      4'd13:   s = 8'h60;
      4'd14:   s = 8'h40;
      4'd15:   s = 8'h41;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/aaap_item_if.sv @@
// aaap_item_if: input item channel (tick, sample or poll plus button level)
// depends on aaap_pkg
interface aaap_item_if #(parameter int SAMPLE_BITS = 10);
  logic                           valid;
  logic                           ready;
  logic [aaap_pkg::KIND_BITS-1:0] kind;
  logic [SAMPLE_BITS-1:0]         sample;
  logic                           button_held;

  modport source (output valid, kind, sample, button_held, input ready);
  modport sink   (input valid, kind, sample, button_held, output ready);
endinterface

@@ hw/rtl/aaap_result_if.sv @@
// aaap_result_if: result channel carrying power enable and display pattern
// depends on aaap_pkg
interface aaap_result_if;
  logic                          valid;
  logic                          ready;
  logic                          power_on;
  logic [aaap_pkg::SEG_BITS-1:0] segments;

  modport source (output valid, power_on, segments, input ready);
  modport sink   (input valid, power_on, segments, output ready);
endinterface

@@ hw/rtl/aaap_cfg_if.sv @@
// aaap_cfg_if: configuration write channel, register index and write data
// depends on aaap_pkg
interface aaap_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [aaap_pkg::CFG_INDEX_BITS-1:0] index;
  logic [aaap_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/aaap_lane.sv @@
// aaap_lane: digit-serial add/subtract lane, one 4-bit digit per cycle while ctl.shift is high, lsb first
// depends on aaap_pkg (word and digit widths, lane_ctl_t)
module aaap_lane (
  input  logic                             clk,
  input  aaap_pkg::lane_ctl_t              ctl,
  input  logic [aaap_pkg::WORD_BITS-1:0]   a,
  input  logic [aaap_pkg::WORD_BITS-1:0]   b,
  output logic [aaap_pkg::WORD_BITS-1:0]   sum,
  output logic                             carry
);

  localparam int W = aaap_pkg::WORD_BITS;
  localparam int D = aaap_pkg::DIGIT_BITS;

  logic [W-1:0] a_sh;
  logic [W-1:0] b_sh;
  logic [W-1:0] r_sh;
  logic         c;
  logic [D:0]   dsum;

  assign dsum = {1'b0, a_sh[D-1:0]} + {1'b0, b_sh[D-1:0]} + {{D{1'b0}}, c};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_sh <= a;
      b_sh <= ctl.sub ? ~b : b;
      c    <= ctl.sub;
    end else if (ctl.shift) begin
      a_sh <= a_sh >> D;
      b_sh <= b_sh >> D;
      r_sh <= {dsum[D-1:0], r_sh[W-1:D]};
      c    <= dsum[D];
    end
  end

  assign sum   = r_sh;
  assign carry = c;

endmodule

@@ hw/rtl/audio_activity_auto_power_unit.sv @@
// audio_activity_auto_power_unit: idle/button counters, power decision and
// status display; depends on aaap_pkg, aaap_lane and the three channel interfaces
// a poll runs passes P3-P7, a tick P1 and P3-P7, a sample P1-P7; FIN waits
// until any earlier result is taken, and the next item is accepted after FIN
// each step is a pass of four 4-bit digit-serial lanes over 24-bit words
// rst (synchronous) restores control state, limits and counters, no clearing pass
module audio_activity_auto_power_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic          clk,
  input  logic          rst,
  aaap_item_if.sink     item,
  aaap_result_if.source result,
  aaap_cfg_if.sink      cfg
);

  localparam int W   = aaap_pkg::WORD_BITS;
  localparam int NL  = aaap_pkg::LANES;
  localparam int CB  = aaap_pkg::CNT_BITS;
  localparam int IB  = aaap_pkg::IDLE_BITS;
  localparam int BB  = aaap_pkg::BUTTON_BITS;
  localparam int SB  = aaap_pkg::STEP_BITS;
  localparam int TB  = aaap_pkg::THRESH_BITS;
  localparam int FB  = aaap_pkg::FIVE_BITS;
  localparam int RB  = aaap_pkg::REM_BITS;
  localparam int LB  = aaap_pkg::LEVEL_BITS;
  localparam int SPB = aaap_pkg::SPIN_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_P2   = 4'd2;
  localparam logic [3:0] S_P3   = 4'd3;
  localparam logic [3:0] S_P4   = 4'd4;
  localparam logic [3:0] S_P5   = 4'd5;
  localparam logic [3:0] S_P6   = 4'd6;
  localparam logic [3:0] S_P7   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]    state;
  logic [CB-1:0] cnt;

  logic [aaap_pkg::KIND_BITS-1:0] kind_r;
  logic [SAMPLE_BITS-1:0]         sample_r;
  logic                           held_r;

  logic [TB-1:0] thresh;
  logic [IB-1:0] idle_lim;
  logic [BB-1:0] btn_lim;

  logic [IB-1:0]          idle;
  logic [BB-1:0]          btn;
  logic [SB-1:0]          step;
  logic [SAMPLE_BITS-1:0] prev;
  logic [SPB-1:0]         spin;
  logic                   power;

  logic [SAMPLE_BITS-1:0] diff;
  logic [FB-1:0]          five_i;
  logic [RB-1:0]          rem;
  logic [LB-1:0]          quot;
  logic                   clamp;
  logic                   bge;
  logic                   ige;

  logic pass_on;
  logic load;
  logic shift;
  logic finish;

  logic [SB-1:0] step2;
  logic [BB-1:0] bclr;
  logic [W-1:0]  lim_sh;
  logic [LB-1:0] level;
  logic [aaap_pkg::SEG_BITS-1:0] seg_next;
  logic          kind_tick;

  logic [W-1:0]        lane_a   [NL];
  logic [W-1:0]        lane_b   [NL];
  logic                lane_sub [NL];
  aaap_pkg::lane_ctl_t lane_ctl [NL];
  logic [W-1:0]        lane_sum [NL];
  logic                lane_c   [NL];

  assign pass_on = (state != S_IDLE) && (state != S_FIN);
  assign load    = pass_on && (cnt == '0);
  assign shift   = pass_on && (cnt != '0) && (cnt <= CB'(aaap_pkg::DIGITS));
  assign finish  = pass_on && (cnt == CB'(aaap_pkg::DIGITS + 1));

  assign kind_tick = (kind_r == aaap_pkg::KIND_TICK);
  assign step2     = step[SB-1] ? step : {step[SB-2:0], 1'b0};
  assign bclr      = held_r ? '0 : btn;
  assign level     = clamp ? '1 : quot;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_comb begin
    case (state)
      S_P4:    lim_sh = W'({idle_lim, 3'b000});
      S_P5:    lim_sh = W'({idle_lim, 2'b00});
      S_P6:    lim_sh = W'({idle_lim, 1'b0});
      default: lim_sh = W'(idle_lim);
    endcase
  end

  // operand routing per pass
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_a[i]   = '0;
      lane_b[i]   = '0;
      lane_sub[i] = 1'b0;
    end
    case (state)
      S_P1: begin
        if (kind_tick) begin
          lane_a[0] = W'(idle);     lane_b[0] = W'(idle_lim); lane_sub[0] = 1'b1;
          lane_a[1] = W'(idle);     lane_b[1] = W'(1'b1);
        end else begin
          lane_a[0] = W'(sample_r); lane_b[0] = W'(prev);     lane_sub[0] = 1'b1;
          lane_a[1] = W'(prev);     lane_b[1] = W'(sample_r); lane_sub[1] = 1'b1;
        end
        lane_a[2] = W'(btn); lane_b[2] = W'(btn_lim); lane_sub[2] = 1'b1;
        lane_a[3] = W'(btn); lane_b[3] = W'(1'b1);
      end
      S_P2: begin
        lane_a[0] = W'(thresh); lane_b[0] = W'(diff);  lane_sub[0] = 1'b1;
        lane_a[1] = W'(idle);   lane_b[1] = W'(step2); lane_sub[1] = 1'b1;
      end
      S_P3: begin
        lane_a[0] = W'({idle, 2'b00}); lane_b[0] = W'(idle);
        lane_a[1] = W'({idle, 4'b0000}); lane_b[1] = W'(idle); lane_sub[1] = 1'b1;
        lane_a[2] = W'(bclr); lane_b[2] = W'(btn_lim);  lane_sub[2] = 1'b1;
        lane_a[3] = W'(idle); lane_b[3] = W'(idle_lim); lane_sub[3] = 1'b1;
      end
      S_P4: begin
        lane_a[0] = W'(idle_lim); lane_b[0] = W'(five_i); lane_sub[0] = 1'b1;
        lane_a[1] = W'(rem); lane_b[1] = W'({idle_lim, 4'b0000}); lane_sub[1] = 1'b1;
        lane_a[2] = W'(rem); lane_b[2] = lim_sh; lane_sub[2] = 1'b1;
      end
      S_P5, S_P6, S_P7: begin
        lane_a[2] = W'(rem); lane_b[2] = lim_sh; lane_sub[2] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    assign lane_ctl[g] = '{load: load, shift: shift, sub: lane_sub[g]};
    aaap_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl[g]),
      .a     (lane_a[g]),
      .b     (lane_b[g]),
      .sum   (lane_sum[g]),
      .carry (lane_c[g])
    );
  end

  always_comb begin
    if (bge) begin
      seg_next = aaap_pkg::digit_seg(level);
      seg_next[aaap_pkg::SEG_DP_BIT] = seg_next[aaap_pkg::SEG_DP_BIT] | power;
    end else begin
      seg_next = aaap_pkg::spin_seg(spin);
    end
  end

  // control, configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result.valid <= 1'b0;
      thresh       <= aaap_pkg::THRESH_RESET;
      idle_lim     <= aaap_pkg::IDLE_LIMIT_RESET;
      btn_lim      <= aaap_pkg::BTN_LIMIT_RESET;
      idle         <= aaap_pkg::IDLE_LIMIT_RESET;
      btn          <= aaap_pkg::BTN_LIMIT_RESET;
      step         <= aaap_pkg::STEP_RESET;
      prev         <= '0;
      spin         <= '0;
      power        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          aaap_pkg::CFG_THRESH:     thresh   <= cfg.data[TB-1:0];
          aaap_pkg::CFG_IDLE_LIMIT: idle_lim <= cfg.data[IB-1:0];
          aaap_pkg::CFG_BTN_LIMIT:  btn_lim  <= cfg.data[BB-1:0];
          default: begin
          end
        endcase
      end
      if (result.valid && result.ready && state != S_FIN) begin
        result.valid <= 1'b0;
      end
      if (pass_on) begin
        cnt <= finish ? '0 : cnt + 1'b1;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (item.valid) begin
            if (item.kind == aaap_pkg::KIND_TICK || item.kind == aaap_pkg::KIND_SAMPLE) begin
              state <= S_P1;
            end else begin
              state <= S_P3;
            end
          end
        end
        S_P1: begin
          if (finish) begin
            if (kind_tick) begin
              if (!lane_c[0]) begin
                idle <= lane_sum[1][IB-1:0];
              end
              if (!lane_c[2]) begin
                btn <= lane_sum[3][BB-1:0];
                if (lane_sum[3][aaap_pkg::SPIN_LOW-1:0] == '1) begin
                  spin <= spin + 1'b1;
                end
              end
              state <= S_P3;
            end else begin
              prev  <= sample_r;
              state <= S_P2;
            end
          end
        end
        S_P2: begin
          if (finish) begin
            if (!lane_c[0] && idle != '0) begin
              step <= step2;
              idle <= lane_c[1] ? lane_sum[1][IB-1:0] : '0;
            end else begin
              step <= aaap_pkg::STEP_RESET;
            end
            state <= S_P3;
          end
        end
        S_P3: begin
          if (load && held_r) begin
            btn <= '0;
          end
          if (finish) begin
            state <= S_P4;
          end
        end
        S_P4: begin
          if (finish) begin
            if (ige && bge) begin
              power <= 1'b0;
            end else if (lane_c[0] || !bge) begin
              power <= 1'b1;
            end
            state <= S_P5;
          end
        end
        S_P5: begin
          if (finish) begin
            state <= S_P6;
          end
        end
        S_P6: begin
          if (finish) begin
            state <= S_P7;
          end
        end
        S_P7: begin
          if (finish) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      kind_r   <= item.kind;
      sample_r <= item.sample;
      held_r   <= item.button_held;
    end
    if (state == S_P1 && finish && !kind_tick) begin
      diff <= lane_c[0] ? lane_sum[0][SAMPLE_BITS-1:0] : lane_sum[1][SAMPLE_BITS-1:0];
    end
    if (state == S_P3 && finish) begin
      five_i <= lane_sum[0][FB-1:0];
      rem    <= lane_sum[1][RB-1:0];
      bge    <= lane_c[2];
      ige    <= lane_c[3];
    end
    if (state == S_P4 && finish) begin
      clamp <= lane_c[1];
    end
    if ((state == S_P4 || state == S_P5 || state == S_P6 || state == S_P7) && finish) begin
      if (lane_c[2]) begin
        rem <= lane_sum[2][RB-1:0];
      end
      quot <= {quot[LB-2:0], lane_c[2]};
    end
    if (state == S_FIN && (!result.valid || result.ready)) begin
      result.power_on <= power;
      result.segments <= seg_next;
    end
  end

  a_step_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(step))
    else $error("decrement step lost its single set bit");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("second item taken while one is in progress");

  a_spin_tick: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && spin != $past(spin)) |->
      ($past(state) == S_P1 && $past(kind_r) == aaap_pkg::KIND_TICK))
    else $error("spinner moved outside a tick");

endmodule
